### rtl/rob_pkg.sv
// ----------------------------------------------------------------------------
// rob_pkg
// Shared types, codes and reset constants of the retransmitting outbox block.
// ----------------------------------------------------------------------------
package rob_pkg;

    // Default sizes of the outbox array.
    localparam int NUM_DESTS_DEF  = 8;
    localparam int RING_DEPTH_DEF = 4;

    // Galois LFSR feedback taps and generator reset values.
    localparam logic [31:0] LFSR_TAPS    = 32'h8020_0003;
    localparam logic [31:0] ID_LFSR_INIT = 32'h00fe_fefe;

    // Register reset values.
    localparam logic [15:0] FIRST_DELAY_INIT   = 16'd50;
    localparam logic [3:0]  MAX_ATTEMPTS_INIT  = 4'd7;
    localparam logic [3:0]  FAILURE_LIMIT_INIT = 4'd2;
    localparam logic [31:0] BACKOFF_SEED_INIT  = 32'd1;
    localparam logic [7:0]  PRESENT_MASK_INIT  = 8'hff;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FIRST_DELAY   = 3'd0;
    localparam logic [2:0] CFG_MAX_ATTEMPTS  = 3'd1;
    localparam logic [2:0] CFG_FAILURE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_BACKOFF_SEED  = 3'd3;
    localparam logic [2:0] CFG_PRESENT_MASK  = 3'd4;

    // Input item kinds.
    localparam logic [1:0] KIND_PUSH      = 2'd0;
    localparam logic [1:0] KIND_ACK       = 2'd1;
    localparam logic [1:0] KIND_HEARTBEAT = 2'd2;
    localparam logic [1:0] KIND_TICK      = 2'd3;

    // Result kinds.
    localparam logic [2:0] RES_SENT      = 3'd0;
    localparam logic [2:0] RES_QUEUED    = 3'd1;
    localparam logic [2:0] RES_FULL      = 3'd2;
    localparam logic [2:0] RES_UNKNOWN   = 3'd3;
    localparam logic [2:0] RES_ACKED     = 3'd4;
    localparam logic [2:0] RES_SPURIOUS  = 3'd5;
    localparam logic [2:0] RES_HEARTBEAT = 3'd6;

    // One stored outbox entry.
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  cmd;
        logic [31:0] deadline;
        logic [4:0]  backoff;
    } entry_t;

    // One result item without its last flag.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  peer;
        logic [31:0] sent_id;
        logic [7:0]  sent_command;
        logic [4:0]  attempt;
        logic        dropped;
        logic        went_inactive;
    } result_t;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_ACK_CHK  = 7'b0000010,
        ST_EMIT     = 7'b0000100,
        ST_TICK_RD  = 7'b0001000,
        ST_TICK_CHK = 7'b0010000,
        ST_TICK_WR  = 7'b0100000,
        ST_TICK_END = 7'b1000000
    } state_t;

    // One step of the Galois LFSR.
    function automatic logic [31:0] lfsr_next(input logic [31:0] v);
        logic [31:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

### rtl/retransmit_outbox_backoff.sv
// ----------------------------------------------------------------------------
// retransmit_outbox_backoff
// Per-destination ring outboxes with acknowledgment and exponential backoff.
// ----------------------------------------------------------------------------
// One item is taken at a time. Push and heartbeat go straight to the emit
// state; an ack to a destination in range first reads the head entry from
// the entry memory. A tick walks every destination through the entry memory:
// a read state and a check state for each, a write-back state for one that
// sends, and a closing state at the end; the single read port of the entry
// memory and the registered backoff multiply set these steps. Stalls on the
// result side hold the emit, write-back and closing states.
module retransmit_outbox_backoff #(
    parameter int NUM_DESTS  = rob_pkg::NUM_DESTS_DEF,
    parameter int RING_DEPTH = rob_pkg::RING_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // dest[2:0], command[10:3], message_id[42:11], now_ms[74:43]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // peer[2:0], sent_id[34:3], sent_command[42:35],
                                   // attempt[47:43], dropped[48], went_inactive[49]
    output logic [2:0]  m_tuser,   // result_kind[2:0]
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SLOTS = NUM_DESTS * RING_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW    = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
    localparam int PW    = $clog2(RING_DEPTH);

    // Control state.
    rob_pkg::state_t state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [PW-1:0]    wp_reg [NUM_DESTS];
    logic [PW-1:0]    wp_next [NUM_DESTS];
    logic [PW-1:0]    rp_reg [NUM_DESTS];
    logic [PW-1:0]    rp_next [NUM_DESTS];
    logic [3:0]       fail_reg [NUM_DESTS];
    logic [3:0]       fail_next [NUM_DESTS];
    logic [DW-1:0]    td_reg, td_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      id_lfsr_reg, id_lfsr_next;
    logic [31:0]      bo_lfsr_reg, bo_lfsr_next;
    logic [15:0]      first_delay_reg, first_delay_next;
    logic [3:0]       max_att_reg, max_att_next;
    logic [3:0]       fail_lim_reg, fail_lim_next;
    logic [7:0]       present_reg, present_next;

    // Payload registers.
    logic [2:0]        dest_reg, dest_next;
    logic [31:0]       mid_reg, mid_next;
    logic [31:0]       now_reg, now_next;
    rob_pkg::result_t  res_reg, res_next;
    rob_pkg::result_t  pend_reg, pend_next;
    rob_pkg::result_t  out_res_reg, out_res_next;
    logic              out_last_reg, out_last_next;
    logic [31:0]       prod_hi_reg, prod_hi_next;

    // Entry memory: one write port, one registered read port.
    rob_pkg::entry_t mem [SLOTS];
    rob_pkg::entry_t rd_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    rob_pkg::entry_t mem_wdata;

    // Decoded input fields.
    logic [2:0]  in_dest;
    logic [7:0]  in_cmd;
    logic [31:0] in_mid, in_now;
    logic        s_accept, cfg_accept, out_free;

    assign in_dest    = s_tdata[2:0];
    assign in_cmd     = s_tdata[10:3];
    assign in_mid     = s_tdata[42:11];
    assign in_now     = s_tdata[74:43];
    assign s_tready   = (state_reg == rob_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || m_tready;

    // Output port packing.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_res_reg.went_inactive, out_res_reg.dropped,
                       out_res_reg.attempt, out_res_reg.sent_command,
                       out_res_reg.sent_id, out_res_reg.peer};

    function automatic logic [AW-1:0] slot_of(input logic [DW-1:0] d, input logic [PW-1:0] p);
        return AW'(AW'(d) * AW'(RING_DEPTH) + AW'(p));
    endfunction

    function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    // Sequencer and read-modify-write logic.
    always_comb begin
        logic [DW-1:0]   di;
        logic            known;
        logic [AW-1:0]   sl;
        logic [31:0]     idn, bon, span;
        logic [63:0]     prod;
        logic [5:0]      att;
        logic [4:0]      cnt;
        logic            adv;
        rob_pkg::result_t r;

        state_next       = state_reg;
        valid_next       = valid_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        fail_next        = fail_reg;
        td_next          = td_reg;
        pend_valid_next  = pend_valid_reg;
        out_valid_next   = out_valid_reg;
        id_lfsr_next     = id_lfsr_reg;
        bo_lfsr_next     = bo_lfsr_reg;
        first_delay_next = first_delay_reg;
        max_att_next     = max_att_reg;
        fail_lim_next    = fail_lim_reg;
        present_next     = present_reg;
        dest_next        = dest_reg;
        mid_next         = mid_reg;
        now_next         = now_reg;
        res_next         = res_reg;
        pend_next        = pend_reg;
        out_res_next     = out_res_reg;
        out_last_next    = out_last_reg;
        prod_hi_next     = prod_hi_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = '0;
        mem_raddr        = '0;
        mem_wdata        = '0;
        di               = DW'(in_dest);
        known            = 1'b0;
        sl               = '0;
        idn              = '0;
        bon              = '0;
        span             = '0;
        prod             = '0;
        att              = '0;
        cnt              = '0;
        adv              = 1'b0;
        r                = '0;

        // The output register drains whenever the consumer takes it.
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rob_pkg::ST_IDLE: begin
                if (s_accept) begin
                    dest_next = in_dest;
                    mid_next  = in_mid;
                    now_next  = in_now;
                    known     = (32'(in_dest) < NUM_DESTS) && present_reg[in_dest];
                    r         = '0;
                    r.peer    = in_dest;
                    case (s_tuser)
                        rob_pkg::KIND_PUSH: begin
                            sl = slot_of(di, wp_reg[di]);
                            if (!known) begin
                                r.kind = rob_pkg::RES_UNKNOWN;
                            end else if (valid_reg[sl]) begin
                                r.kind = rob_pkg::RES_FULL;
                            end else begin
                                idn            = rob_pkg::lfsr_next(id_lfsr_reg);
                                id_lfsr_next   = idn;
                                mem_we         = 1'b1;
                                mem_waddr      = sl;
                                mem_wdata      = '{id: idn, cmd: in_cmd, deadline: '0,
                                                   backoff: '0};
                                valid_next[sl] = 1'b1;
                                wp_next[di]    = ring_inc(wp_reg[di]);
                                r.kind         = rob_pkg::RES_QUEUED;
                                r.sent_id      = idn;
                            end
                            res_next   = r;
                            state_next = rob_pkg::ST_EMIT;
                        end
                        rob_pkg::KIND_ACK: begin
                            r.kind    = rob_pkg::RES_SPURIOUS;
                            r.sent_id = in_mid;
                            res_next  = r;
                            if (32'(in_dest) < NUM_DESTS) begin
                                mem_re     = 1'b1;
                                mem_raddr  = slot_of(di, rp_reg[di]);
                                state_next = rob_pkg::ST_ACK_CHK;
                            end else begin
                                state_next = rob_pkg::ST_EMIT;
                            end
                        end
                        rob_pkg::KIND_HEARTBEAT: begin
                            r.kind     = rob_pkg::RES_HEARTBEAT;
                            res_next   = r;
                            state_next = rob_pkg::ST_EMIT;
                        end
                        default: begin
                            td_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = rob_pkg::ST_TICK_RD;
                        end
                    endcase
                end
            end

            // Head entry is in the read register: compare and free it.
            rob_pkg::ST_ACK_CHK: begin
                di = DW'(dest_reg);
                sl = slot_of(di, rp_reg[di]);
                if (valid_reg[sl] && rd_reg.id == mid_reg) begin
                    valid_next[sl] = 1'b0;
                    rp_next[di]    = ring_inc(rp_reg[di]);
                    res_next.kind  = rob_pkg::RES_ACKED;
                end
                state_next = rob_pkg::ST_EMIT;
            end

            rob_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_last_next  = 1'b1;
                    state_next     = rob_pkg::ST_IDLE;
                end
            end

            rob_pkg::ST_TICK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = slot_of(td_reg, rp_reg[td_reg]);
                state_next = rob_pkg::ST_TICK_CHK;
            end

            // Check the head entry and start the backoff draw.
            rob_pkg::ST_TICK_CHK: begin
                sl = slot_of(td_reg, rp_reg[td_reg]);
                if (valid_reg[sl] && now_reg > rd_reg.deadline) begin
                    bon          = rob_pkg::lfsr_next(bo_lfsr_reg);
                    bo_lfsr_next = bon;
                    span         = 32'(first_delay_reg) << (6'(rd_reg.backoff) + 6'd1);
                    prod         = 64'(bon) * 64'(span);
                    prod_hi_next = prod[63:32];
                    state_next   = rob_pkg::ST_TICK_WR;
                end else begin
                    adv = 1'b1;
                end
            end

            // Deliver any earlier held result, write back the resent entry and hold its result.
            rob_pkg::ST_TICK_WR: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_res_next   = pend_reg;
                        out_last_next  = 1'b0;
                    end
                    sl        = slot_of(td_reg, rp_reg[td_reg]);
                    att       = 6'(rd_reg.backoff) + 6'd1;
                    mem_we    = 1'b1;
                    mem_waddr = sl;
                    mem_wdata = '{id: rd_reg.id, cmd: rd_reg.cmd,
                                  deadline: now_reg + prod_hi_reg, backoff: att[4:0]};
                    r              = '0;
                    r.kind         = rob_pkg::RES_SENT;
                    r.peer         = 3'(td_reg);
                    r.sent_id      = rd_reg.id;
                    r.sent_command = rd_reg.cmd;
                    r.attempt      = att[4:0];
                    if (att > 6'(max_att_reg)) begin
                        r.dropped       = 1'b1;
                        valid_next[sl]  = 1'b0;
                        rp_next[td_reg] = ring_inc(rp_reg[td_reg]);
                        cnt             = 5'(fail_reg[td_reg]) + 5'd1;
                        if (cnt > 5'(fail_lim_reg)) begin
                            r.went_inactive   = 1'b1;
                            fail_next[td_reg] = '0;
                        end else begin
                            fail_next[td_reg] = cnt[3:0];
                        end
                    end
                    pend_next       = r;
                    pend_valid_next = 1'b1;
                    adv             = 1'b1;
                end
            end

            // Deliver the held result as the final one of the tick.
            rob_pkg::ST_TICK_END: begin
                if (!pend_valid_reg) begin
                    state_next = rob_pkg::ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = rob_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = rob_pkg::ST_IDLE;
            end
        endcase

        // Step to the next destination of a tick.
        if (adv) begin
            if (td_reg == DW'(NUM_DESTS - 1)) begin
                state_next = rob_pkg::ST_TICK_END;
            end else begin
                td_next    = DW'(td_reg + 1'b1);
                state_next = rob_pkg::ST_TICK_RD;
            end
        end

        // Configuration register writes.
        if (cfg_accept) begin
            unique case (cfg_index)
                rob_pkg::CFG_FIRST_DELAY:   first_delay_next = cfg_data[15:0];
                rob_pkg::CFG_MAX_ATTEMPTS:  max_att_next     = cfg_data[3:0];
                rob_pkg::CFG_FAILURE_LIMIT: fail_lim_next    = cfg_data[3:0];
                rob_pkg::CFG_BACKOFF_SEED:  bo_lfsr_next     = (cfg_data == '0) ? 32'd1 : cfg_data;
                rob_pkg::CFG_PRESENT_MASK:  present_next     = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rob_pkg::ST_IDLE;
            valid_reg       <= '0;
            for (int i = 0; i < NUM_DESTS; i++) begin
                wp_reg[i]   <= '0;
                rp_reg[i]   <= '0;
                fail_reg[i] <= '0;
            end
            td_reg          <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            id_lfsr_reg     <= rob_pkg::ID_LFSR_INIT;
            bo_lfsr_reg     <= rob_pkg::BACKOFF_SEED_INIT;
            first_delay_reg <= rob_pkg::FIRST_DELAY_INIT;
            max_att_reg     <= rob_pkg::MAX_ATTEMPTS_INIT;
            fail_lim_reg    <= rob_pkg::FAILURE_LIMIT_INIT;
            present_reg     <= rob_pkg::PRESENT_MASK_INIT;
        end else begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            fail_reg        <= fail_next;
            td_reg          <= td_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            id_lfsr_reg     <= id_lfsr_next;
            bo_lfsr_reg     <= bo_lfsr_next;
            first_delay_reg <= first_delay_next;
            max_att_reg     <= max_att_next;
            fail_lim_reg    <= fail_lim_next;
            present_reg     <= present_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        dest_reg     <= dest_next;
        mid_reg      <= mid_next;
        now_reg      <= now_next;
        res_reg      <= res_next;
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        prod_hi_reg  <= prod_hi_next;
    end

    // Entry memory ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // Checks.
    a_emit_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rob_pkg::ST_EMIT && out_free) |=> (m_tvalid && m_tlast))
        else $error("single result left without last flag");

    a_wr_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rob_pkg::ST_TICK_WR && (!pend_valid_reg || out_free))
        |=> pend_valid_reg)
        else $error("resent entry lost its result");

    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        id_lfsr_reg != '0)
        else $error("message ID generator reached zero");

    a_bo_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        bo_lfsr_reg != '0)
        else $error("backoff generator reached zero");

endmodule

### bench/retransmit_outbox_backoff_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_outbox_backoff_tb
// Drives push, ack, heartbeat and tick transactions into the outbox block under
// several register settings and random flow control. An outbox predictor
// mirrors the rings, ID and backoff generators, and a scoreboard compares every
// result transaction with the oldest predicted one.
// ----------------------------------------------------------------------------

// Outbox predictor and store of predicted results.
class outbox_scoreboard;
    logic [15:0] first_delay;
    logic [3:0]  max_attempts;
    logic [3:0]  failure_limit;
    logic [7:0]  present_mask;
    logic [31:0] id_lfsr;
    logic [31:0] backoff_lfsr;
    logic [31:0] ids [32];
    logic [7:0]  cmds [32];
    logic [31:0] deadlines [32];
    logic [4:0]  backoffs [32];
    logic [1:0]  wr_ptr [8];
    logic [1:0]  rd_ptr [8];
    logic [3:0]  fail_cnt [8];
    logic        active [8];
    rob_pkg::result_t pending_results [$];
    bit          pending_last [$];
    int          errors;

    function new();
        first_delay   = rob_pkg::FIRST_DELAY_INIT;
        max_attempts  = rob_pkg::MAX_ATTEMPTS_INIT;
        failure_limit = rob_pkg::FAILURE_LIMIT_INIT;
        present_mask  = rob_pkg::PRESENT_MASK_INIT;
        id_lfsr       = rob_pkg::ID_LFSR_INIT;
        backoff_lfsr  = rob_pkg::BACKOFF_SEED_INIT;
        errors        = 0;
        for (int i = 0; i < 32; i++) begin
            ids[i] = '0; cmds[i] = '0; deadlines[i] = '0; backoffs[i] = '0;
        end
        for (int d = 0; d < 8; d++) begin
            wr_ptr[d] = '0; rd_ptr[d] = '0; fail_cnt[d] = '0; active[d] = 1'b0;
        end
    endfunction

    function logic [31:0] step_lfsr(logic [31:0] v);
        logic [31:0] s;
        s = v >> 1;
        if (v[0]) s = s ^ rob_pkg::LFSR_TAPS;
        return s;
    endfunction

    function void note_config(logic [2:0] idx, logic [31:0] data);
        case (idx)
            rob_pkg::CFG_FIRST_DELAY:   first_delay = data[15:0];
            rob_pkg::CFG_MAX_ATTEMPTS:  max_attempts = data[3:0];
            rob_pkg::CFG_FAILURE_LIMIT: failure_limit = data[3:0];
            rob_pkg::CFG_BACKOFF_SEED:  backoff_lfsr = (data == 0) ? 32'd1 : data;
            rob_pkg::CFG_PRESENT_MASK:  present_mask = data[7:0];
            default: ;
        endcase
    endfunction

    function void add(logic [2:0] k, logic [2:0] p, logic [31:0] id, logic [7:0] c,
                      logic [4:0] a, logic dr, logic ia);
        rob_pkg::result_t r;
        r.kind = k; r.peer = p; r.sent_id = id; r.sent_command = c;
        r.attempt = a; r.dropped = dr; r.went_inactive = ia;
        pending_results.push_back(r);
        pending_last.push_back(1'b0);
    endfunction

    // Predict the results of one accepted input transaction.
    function void note_input(logic [1:0] kind, logic [2:0] dest, logic [7:0] cmd,
                             logic [31:0] mid, logic [31:0] now);
        int n0, slot;
        logic [4:0]  bo;
        logic [63:0] span, prod;
        logic [3:0]  c;
        logic        dr, ia;
        logic [31:0] id;
        n0 = pending_results.size();
        case (kind)
            rob_pkg::KIND_PUSH: begin
                slot = dest * 4 + wr_ptr[dest];
                if (!present_mask[dest]) add(rob_pkg::RES_UNKNOWN, dest, 0, 0, 0, 0, 0);
                else if (ids[slot] != 0) add(rob_pkg::RES_FULL, dest, 0, 0, 0, 0, 0);
                else begin
                    id_lfsr = step_lfsr(id_lfsr);
                    ids[slot] = id_lfsr; cmds[slot] = cmd;
                    backoffs[slot] = 0; deadlines[slot] = 0;
                    wr_ptr[dest] = wr_ptr[dest] + 1;
                    add(rob_pkg::RES_QUEUED, dest, id_lfsr, 0, 0, 0, 0);
                end
            end
            rob_pkg::KIND_ACK: begin
                slot = dest * 4 + rd_ptr[dest];
                if (ids[slot] != 0 && ids[slot] == mid) begin
                    ids[slot] = 0;
                    rd_ptr[dest] = rd_ptr[dest] + 1;
                    add(rob_pkg::RES_ACKED, dest, mid, 0, 0, 0, 0);
                end else begin
                    add(rob_pkg::RES_SPURIOUS, dest, mid, 0, 0, 0, 0);
                end
            end
            rob_pkg::KIND_HEARTBEAT: begin
                active[dest] = 1'b1;
                add(rob_pkg::RES_HEARTBEAT, dest, 0, 0, 0, 0, 0);
            end
            default: begin
                for (int d = 0; d < 8; d++) begin
                    slot = d * 4 + rd_ptr[d];
                    id = ids[slot];
                    if (id == 0 || !(now > deadlines[slot])) continue;
                    bo = backoffs[slot];
                    span = 64'(first_delay) << (bo + 1);
                    if (span > 64'hffff_ffff) span = 64'hffff_ffff;
                    backoff_lfsr = step_lfsr(backoff_lfsr);
                    prod = 64'(backoff_lfsr) * span;
                    deadlines[slot] = now + prod[63:32];
                    backoffs[slot] = bo + 1;
                    dr = 0; ia = 0;
                    if (32'(bo) + 1 > 32'(max_attempts)) begin
                        c = fail_cnt[d] + 1;
                        dr = 1;
                        ids[slot] = 0;
                        rd_ptr[d] = rd_ptr[d] + 1;
                        if (5'(fail_cnt[d]) + 1 > 5'(failure_limit)) begin
                            active[d] = 0; c = 0; ia = 1;
                        end
                        fail_cnt[d] = c;
                    end
                    add(rob_pkg::RES_SENT, 3'(d), id, cmds[slot], bo + 1, dr, ia);
                end
            end
        endcase
        if (pending_results.size() > n0) pending_last[pending_last.size() - 1] = 1'b1;
    endfunction

    function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: result %s is %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endfunction

    // Compare one accepted result transaction with the oldest prediction.
    function void check_result(logic [2:0] kind, logic [55:0] data, logic last);
        rob_pkg::result_t w;
        bit wl;
        if (pending_results.size() == 0) begin
            $display("%0t ns: result with none predicted", $realtime);
            errors++;
            return;
        end
        w = pending_results.pop_front();
        wl = pending_last.pop_front();
        if (kind != w.kind) report_mismatch("kind", kind, w.kind);
        if (data[2:0] != w.peer) report_mismatch("peer", data[2:0], w.peer);
        if (data[34:3] != w.sent_id) report_mismatch("sent_id", data[34:3], w.sent_id);
        if (data[42:35] != w.sent_command)
            report_mismatch("sent_command", data[42:35], w.sent_command);
        if (data[47:43] != w.attempt) report_mismatch("attempt", data[47:43], w.attempt);
        if (data[48] != w.dropped) report_mismatch("dropped", data[48], w.dropped);
        if (data[49] != w.went_inactive)
            report_mismatch("went_inactive", data[49], w.went_inactive);
        if (data[55:50] != 0) report_mismatch("pad", data[55:50], 0);
        if (last != wl) report_mismatch("last", last, wl);
    endfunction
endclass

module retransmit_outbox_backoff_tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    outbox_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    logic [31:0] clock_ms = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    retransmit_outbox_backoff i_dut (.*);

    // Result side: random stalls plus an optional long hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata, m_tlast);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [2:0] dest, logic [7:0] cmd,
                             logic [31:0] mid, logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, now, mid, cmd, dest};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(kind, dest, cmd, mid, now);
        s_tvalid <= 1'b0;
        // The block drops s_tready after taking an item.
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.note_config(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic tick(logic [31:0] advance);
        clock_ms = clock_ms + advance;
        send_item(rob_pkg::KIND_TICK, 3'($urandom), 8'($urandom), $urandom, clock_ms);
    endtask

    // Head ID of a destination, taken from the predictor for well-formed acks.
    function automatic logic [31:0] head_id(logic [2:0] d);
        return board.ids[d * 4 + board.rd_ptr[d]];
    endfunction

    // Random traffic, mostly push/ack/tick with valid head IDs.
    task automatic random_phase(int count);
        logic [2:0] d;
        int r;
        for (int i = 0; i < count; i++) begin
            d = 3'($urandom);
            r = $urandom_range(99);
            if (r < 35) send_item(rob_pkg::KIND_PUSH, d, 8'($urandom), $urandom, $urandom);
            else if (r < 55) send_item(rob_pkg::KIND_ACK, d, 8'($urandom),
                                       ($urandom_range(3) != 0) ? head_id(d) : $urandom,
                                       $urandom);
            else if (r < 62) send_item(rob_pkg::KIND_HEARTBEAT, d, 8'($urandom), $urandom,
                                       $urandom);
            else if (r < 95) tick($urandom_range(2000));
            else tick($urandom);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed: extremes, every kind and the special cases.
        send_item(rob_pkg::KIND_PUSH, 3'd0, 8'h00, 32'h0, 32'h0);
        send_item(rob_pkg::KIND_PUSH, 3'd0, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(rob_pkg::KIND_ACK, 3'd1, 8'h00, 32'h0, 32'h0);          // empty head, ID zero
        send_item(rob_pkg::KIND_ACK, 3'd0, 8'hff, 32'hffff_ffff, 32'h0);  // wrong ID
        send_item(rob_pkg::KIND_ACK, 3'd0, 8'h00, head_id(3'd0), 32'h0);
        send_item(rob_pkg::KIND_HEARTBEAT, 3'd7, 8'hff, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 5; i++) send_item(rob_pkg::KIND_PUSH, 3'd7, 8'(i), 0, 0); // ring full
        send_item(rob_pkg::KIND_TICK, 3'd7, 8'h00, 32'h0, 32'h0);         // quiet tick
        for (int i = 0; i < 10; i++)
            send_item(rob_pkg::KIND_TICK, 3'd0, 0, 0, 32'hffff_ffff);
        drain();

        // Tight settings: a first delay of one, zero seed, one attempt, no failure slack.
        write_reg(rob_pkg::CFG_FIRST_DELAY, 32'd1);
        write_reg(rob_pkg::CFG_MAX_ATTEMPTS, 32'd1);
        write_reg(rob_pkg::CFG_FAILURE_LIMIT, 32'd0);
        write_reg(rob_pkg::CFG_BACKOFF_SEED, 32'd0);
        write_reg(rob_pkg::CFG_PRESENT_MASK, 32'h5a);
        send_item(rob_pkg::KIND_PUSH, 3'd0, 8'h11, 0, 0);                // unknown destination
        send_item(rob_pkg::KIND_HEARTBEAT, 3'd0, 0, 0, 0);
        send_item(rob_pkg::KIND_ACK, 3'd0, 0, 0, 0);
        for (int d = 0; d < 8; d++) send_item(rob_pkg::KIND_PUSH, 3'(d), 8'(d), 0, 0);
        // Hold the receiver off so the block backs up.
        hold_cycles = 300;
        for (int i = 0; i < 3; i++) tick(32'd5);
        drain();

        // Wide settings with the sender idling less than the receiver.
        write_reg(rob_pkg::CFG_FIRST_DELAY, 32'hffff);
        write_reg(rob_pkg::CFG_MAX_ATTEMPTS, 32'd15);
        write_reg(rob_pkg::CFG_FAILURE_LIMIT, 32'd15);
        write_reg(rob_pkg::CFG_BACKOFF_SEED, 32'hffff_ffff);
        write_reg(rob_pkg::CFG_PRESENT_MASK, 32'hff);
        send_idle_pct = 36; recv_idle_pct = 64;
        random_phase(20);
        drain();

        // Fast retries and the other idling mix.
        write_reg(rob_pkg::CFG_FIRST_DELAY, 32'd3);
        write_reg(rob_pkg::CFG_MAX_ATTEMPTS, 32'd3);
        write_reg(rob_pkg::CFG_FAILURE_LIMIT, 32'd1);
        write_reg(rob_pkg::CFG_BACKOFF_SEED, $urandom | 32'd1);
        write_reg(rob_pkg::CFG_PRESENT_MASK, 32'($urandom_range(255)) | 32'h81);
        send_idle_pct = 64; recv_idle_pct = 36;
        random_phase(22);
        drain();

        // Default delay, attempt, failure and mask settings, no idling at all.
        write_reg(rob_pkg::CFG_FIRST_DELAY, 32'd50);
        write_reg(rob_pkg::CFG_MAX_ATTEMPTS, 32'd7);
        write_reg(rob_pkg::CFG_FAILURE_LIMIT, 32'd2);
        write_reg(rob_pkg::CFG_PRESENT_MASK, 32'hff);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(22);
        drain();

        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (board.pending_results.size() != 0)
                $display("%0d predicted results never arrived", board.pending_results.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout waiting for the block");
        $display("Simulation FAILED");
        $finish;
    end
endmodule
